[rtl/spp_pkg.sv]
`default_nettype none

package spp_pkg;

    localparam int DATA_W = 32;

    // action codes of an input word
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     last_flag;
        logic                     empty_flag;
        logic                     overflow_flag;
    } out_word_t;

    // strobes toward the two element stores
    typedef struct packed {
        logic below_we;
        logic below_re;
        logic above_we;
        logic above_re;
    } mem_ctl_t;

endpackage

`default_nettype wire

[rtl/stable_pivot_partition.sv]
// Stable three-way partition around a programmable pivot.
// Config: write cfg_wr_data with cfg_wr_en high to set the signed pivot (reset 0);
// write it only while no read is in flight.
// Input channel (s_valid/s_ready/s_data) takes one word per accept: action CLEAR
// starts a new set, LOAD files element_value below or above the pivot in arrival
// order (equals are only counted), READ asks for the next element of the
// sequence below..., pivot per equal..., above.... Action 3 is ignored.
// Output channel (m_valid/m_ready/m_data) gives one word per READ, with
// last_flag on the final element, empty_flag when nothing is left, and
// overflow_flag when a load of this set was dropped for lack of room.
// CLEAR and LOAD are taken back to back. An accepted READ moves to state ST_READ
// while the element stores do their registered read; from ST_READ its word goes
// into the output register that drives m_valid, once that register is free.
// When m_ready stalls, a finished word waits in the output register while
// loads and clears keep flowing; a further READ is taken, then holds s_ready
// low until the register frees.
// Reset clears counters, pivot, drop flag and m_valid; store contents are kept
// and need no clearing pass, since a read only reaches entries of this set.
`default_nettype none

module stable_pivot_partition #(
    parameter int SET_DEPTH = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic signed [spp_pkg::DATA_W-1:0] cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire spp_pkg::in_word_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output spp_pkg::out_word_t                     m_data
);

    import spp_pkg::*;

    localparam int ADDR_W = $clog2(SET_DEPTH);

    mem_ctl_t            mem_ctl;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [DATA_W-1:0]   mem_wr_data;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [DATA_W-1:0]   below_rd_data;
    logic [DATA_W-1:0]   above_rd_data;

    // sequencer: counters, pivot, read position and output register
    spp_ctrl #(
        .SET_DEPTH (SET_DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .mem_ctl       (mem_ctl),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr   (mem_rd_addr),
        .below_rd_data (below_rd_data),
        .above_rd_data (above_rd_data)
    );

    // elements below the pivot, in arrival order
    spp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_DEPTH)
    ) u_below_ram (
        .aclk    (aclk),
        .wr_en   (mem_ctl.below_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_ctl.below_re),
        .rd_addr (mem_rd_addr),
        .rd_data (below_rd_data)
    );

    // elements above the pivot, in arrival order
    spp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_DEPTH)
    ) u_above_ram (
        .aclk    (aclk),
        .wr_en   (mem_ctl.above_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_ctl.above_re),
        .rd_addr (mem_rd_addr),
        .rd_data (above_rd_data)
    );

    // at most one store access per cycle
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mem_ctl.below_we, mem_ctl.below_re, mem_ctl.above_we, mem_ctl.above_re}))
        else $error("more than one store access in a cycle");

    // a store write only follows an accepted load
    a_write_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctl.below_we || mem_ctl.above_we) |->
        (s_valid && s_ready && s_data.action == ACT_LOAD))
        else $error("store write without an accepted load");

    // a store read only follows an accepted read
    a_read_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctl.below_re || mem_ctl.above_re) |->
        (s_valid && s_ready && s_data.action == ACT_READ))
        else $error("store read without an accepted read");

    // hold off input while a read is being finished
    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.action == ACT_READ) |=> !s_ready)
        else $error("input accepted while a read is in flight");

endmodule

`default_nettype wire

[rtl/spp_ram.sv]
`default_nettype none

module spp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/spp_ctrl.sv]
`default_nettype none

module spp_ctrl #(
    parameter int SET_DEPTH = 1024,
    localparam int ADDR_W = $clog2(SET_DEPTH),
    localparam int CNT_W  = $clog2(SET_DEPTH + 1)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic signed [spp_pkg::DATA_W-1:0] cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire spp_pkg::in_word_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output spp_pkg::out_word_t                     m_data,
    output spp_pkg::mem_ctl_t                      mem_ctl,
    output logic [ADDR_W-1:0]                      mem_wr_addr,
    output logic [spp_pkg::DATA_W-1:0]             mem_wr_data,
    output logic [ADDR_W-1:0]                      mem_rd_addr,
    input  wire logic [spp_pkg::DATA_W-1:0]        below_rd_data,
    input  wire logic [spp_pkg::DATA_W-1:0]        above_rd_data
);

    import spp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_BELOW,
        SRC_PIVOT,
        SRC_ABOVE
    } src_t;

    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic [CNT_W-1:0]         below_cnt_reg, below_cnt_next;
    logic [CNT_W-1:0]         above_cnt_reg, above_cnt_next;
    logic [CNT_W-1:0]         equal_cnt_reg, equal_cnt_next;
    logic [CNT_W-1:0]         rd_pos_reg, rd_pos_next;
    logic                     dropped_reg, dropped_next;
    logic                     m_valid_reg, m_valid_next;
    src_t                     pend_src_reg, pend_src_next;
    logic                     pend_last_reg, pend_last_next;
    logic                     pend_ovf_reg, pend_ovf_next;
    out_word_t                m_data_reg, m_data_next;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] below_equal;
    logic [CNT_W-1:0] above_pos;
    logic [CNT_W-1:0] rd_pos_inc;

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign below_equal = below_cnt_reg + equal_cnt_reg;
    assign total       = below_equal + above_cnt_reg;
    assign above_pos   = rd_pos_reg - below_equal;
    assign rd_pos_inc  = rd_pos_reg + CNT_W'(1);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        pivot_next     = pivot_reg;
        below_cnt_next = below_cnt_reg;
        above_cnt_next = above_cnt_reg;
        equal_cnt_next = equal_cnt_reg;
        rd_pos_next    = rd_pos_reg;
        dropped_next   = dropped_reg;
        pend_src_next  = pend_src_reg;
        pend_last_next = pend_last_reg;
        pend_ovf_next  = pend_ovf_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        mem_ctl     = '0;
        mem_wr_addr = below_cnt_reg[ADDR_W-1:0];
        mem_wr_data = s_data.element_value;
        mem_rd_addr = rd_pos_reg[ADDR_W-1:0];

        if (cfg_wr_en) begin
            pivot_next = cfg_wr_data;
        end

        // drain the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.action)
                        ACT_CLEAR: begin
                            below_cnt_next = '0;
                            above_cnt_next = '0;
                            equal_cnt_next = '0;
                            rd_pos_next    = '0;
                            dropped_next   = 1'b0;
                        end
                        ACT_LOAD: begin
                            if (total >= CNT_W'(SET_DEPTH)) begin
                                dropped_next = 1'b1;
                            end else if (s_data.element_value < pivot_reg) begin
                                mem_ctl.below_we = 1'b1;
                                below_cnt_next   = below_cnt_reg + CNT_W'(1);
                            end else if (s_data.element_value > pivot_reg) begin
                                mem_ctl.above_we = 1'b1;
                                mem_wr_addr      = above_cnt_reg[ADDR_W-1:0];
                                above_cnt_next   = above_cnt_reg + CNT_W'(1);
                            end else begin
                                equal_cnt_next = equal_cnt_reg + CNT_W'(1);
                            end
                        end
                        ACT_READ: begin
                            pend_ovf_next  = dropped_reg;
                            pend_last_next = 1'b0;
                            state_next     = ST_READ;
                            if (rd_pos_reg >= total) begin
                                pend_src_next = SRC_NONE;
                            end else begin
                                rd_pos_next    = rd_pos_inc;
                                pend_last_next = (rd_pos_inc == total);
                                if (rd_pos_reg < below_cnt_reg) begin
                                    pend_src_next    = SRC_BELOW;
                                    mem_ctl.below_re = 1'b1;
                                end else if (rd_pos_reg < below_equal) begin
                                    pend_src_next = SRC_PIVOT;
                                end else begin
                                    pend_src_next    = SRC_ABOVE;
                                    mem_ctl.above_re = 1'b1;
                                    mem_rd_addr      = above_pos[ADDR_W-1:0];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // store data is valid now; hold it until the output slot frees
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.last_flag     = pend_last_reg;
                    m_data_next.empty_flag    = (pend_src_reg == SRC_NONE);
                    m_data_next.overflow_flag = pend_ovf_reg;
                    case (pend_src_reg)
                        SRC_BELOW: m_data_next.result_value = below_rd_data;
                        SRC_ABOVE: m_data_next.result_value = above_rd_data;
                        SRC_PIVOT: m_data_next.result_value = pivot_reg;
                        default:   m_data_next.result_value = '0;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pivot_reg     <= '0;
            below_cnt_reg <= '0;
            above_cnt_reg <= '0;
            equal_cnt_reg <= '0;
            rd_pos_reg    <= '0;
            dropped_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pivot_reg     <= pivot_next;
            below_cnt_reg <= below_cnt_next;
            above_cnt_reg <= above_cnt_next;
            equal_cnt_reg <= equal_cnt_next;
            rd_pos_reg    <= rd_pos_next;
            dropped_reg   <= dropped_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_src_reg  <= pend_src_next;
        pend_last_reg <= pend_last_next;
        pend_ovf_reg  <= pend_ovf_next;
        m_data_reg    <= m_data_next;
    end

endmodule

`default_nettype wire
